// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the top RTL file of the option pricer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property check failed");
`define BTO_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define BTO_ASSERT(lbl, prop)
`define BTO_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/bto_pkg.sv =====
// Shared constants, types and fixed-point helpers of the binomial option pricer.
package bto_pkg;

  localparam int STEPS_MAX = 128;
  localparam int NUM_CELLS = STEPS_MAX + 1;
  localparam int LVL_W = $clog2(STEPS_MAX + 1);

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_NUM_STEPS = 3'd1;
  localparam logic [2:0] CFG_UP = 3'd2;
  localparam logic [2:0] CFG_DOWN = 3'd3;
  localparam logic [2:0] CFG_PROB = 3'd4;
  localparam logic [2:0] CFG_DISC = 3'd5;

  localparam logic [1:0] RST_MODE = 2'd0;
  localparam logic [7:0] RST_NUM_STEPS = 8'd100;
  localparam logic [31:0] RST_UP = 32'd1140850688;
  localparam logic [31:0] RST_DOWN = 32'd1006632960;
  localparam logic [30:0] RST_PROB = 31'd536870912;
  localparam logic [30:0] RST_DISC = 31'd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_COMB_A,
    ST_COMB_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic leaf;
    logic comb_a;
    logic comb_b;
    logic put;
    logic american;
  } cell_ctrl_t;

  // Rounded product by a Q2.30 factor; bit 32 flags a clipped result.
  function automatic logic [32:0] mulq(input logic [31:0] x, input logic [31:0] f);
    logic [64:0] s;
    logic [34:0] r;
    s = 65'(x) * 65'(f) + 65'(HALF_Q30);
    r = s[64:30];
    if (r > 35'(MAX32)) begin
      mulq = {1'b1, MAX32};
    end else begin
      mulq = {1'b0, r[31:0]};
    end
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
                                         input logic put);
    if (put) begin
      payoff = (k > s) ? k - s : 32'd0;
    end else begin
      payoff = (s > k) ? s - k : 32'd0;
    end
  endfunction

endpackage

// ===== hw/rtl/bto_source.sv =====
// Head of the price lane: spot multiplied by the up factor once per cycle while load is low.
module bto_source (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] spot,
  input  logic [31:0] up,
  output logic [31:0] price,
  output logic        clip
);
  import bto_pkg::*;

  logic [31:0] price_r, price_nxt;
  logic        clip_r, clip_nxt;
  logic [32:0] prod;

  always_comb begin
    prod = mulq(price_r, up);
    if (load) begin
      price_nxt = spot;
      clip_nxt  = 1'b0;
    end else begin
      price_nxt = prod[31:0];
      clip_nxt  = clip_r | prod[32];
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    clip_r  <= clip_nxt;
  end

  assign price = price_r;
  assign clip  = clip_r;

endmodule

// ===== hw/rtl/bto_cell.sv =====
// One tree node cell: a down-factor lane stage plus the node value and its update.
module bto_cell (
  input  logic                clk,
  input  bto_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]         down,
  input  logic [30:0]         q,
  input  logic [30:0]         disc,
  input  logic [31:0]         strike,
  input  logic [31:0]         lane_in,
  input  logic                lane_in_clip,
  output logic [31:0]         lane_out,
  output logic                lane_out_clip,
  input  logic [31:0]         val_right,
  input  logic                flag_right,
  output logic [31:0]         val_out,
  output logic                flag_out
);
  import bto_pkg::*;

  logic [31:0] lane_r, lane_nxt;
  logic        lane_clip_r, lane_clip_nxt;
  logic [31:0] stock_r, stock_nxt;
  logic [31:0] val_r, val_nxt;
  logic        flag_r, flag_nxt;
  logic [31:0] mean_r, mean_nxt;
  logic [32:0] lane_prod;
  logic [32:0] disc_prod;
  logic [31:0] pay_in, pay_stock;
  logic signed [33:0] diff;
  logic signed [65:0] sum;

  always_comb begin
    lane_prod     = mulq(lane_in, down);
    lane_nxt      = lane_prod[31:0];
    lane_clip_nxt = lane_in_clip | lane_prod[32];

    pay_in    = payoff(lane_in, strike, ctrl.put);
    pay_stock = payoff(stock_r, strike, ctrl.put);

    // q*Vup + (1-q)*Vdown written as Vdown + q*(Vup - Vdown).
    diff = $signed({2'b00, val_r}) - $signed({2'b00, val_right});
    sum  = $signed({1'b0, q}) * diff + $signed({4'b0000, val_right, 30'd0})
           + $signed({34'd0, HALF_Q30});
    mean_nxt = ctrl.comb_a ? sum[61:30] : mean_r;

    disc_prod = mulq(mean_r, {1'b0, disc});

    stock_nxt = ctrl.capture ? lane_in : stock_r;
    val_nxt   = val_r;
    flag_nxt  = flag_r;
    if (ctrl.capture && ctrl.leaf) begin
      val_nxt  = pay_in;
      flag_nxt = lane_in_clip;
    end else if (ctrl.comb_b) begin
      val_nxt  = (ctrl.american && pay_stock > disc_prod[31:0]) ? pay_stock
                                                                : disc_prod[31:0];
      flag_nxt = flag_r | flag_right;
    end
  end

  always_ff @(posedge clk) begin
    lane_r      <= lane_nxt;
    lane_clip_r <= lane_clip_nxt;
    stock_r     <= stock_nxt;
    val_r       <= val_nxt;
    flag_r      <= flag_nxt;
    mean_r      <= mean_nxt;
  end

  assign lane_out      = lane_r;
  assign lane_out_clip = lane_clip_r;
  assign val_out       = val_r;
  assign flag_out      = flag_r;

endmodule

// ===== hw/rtl/binomial_tree_option_pricer.sv =====
// Stock prices are built by streaming up-factor products down the cell lane, one cell per
// cycle: once for the leaves, and again for every level in American mode; each backward
// level then runs the COMB_A and COMB_B states in all cells.
// One request at a time: a new one is taken only after the result moves to the output.
// Reset clears control and loads the default configuration; node storage is not cleared.
module binomial_tree_option_pricer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // spot_price [31:0], strike [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // option_value [31:0]
  output logic [0:0]  out_tuser,  // saturated [0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import bto_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  logic [1:0]  mode_r;
  logic [7:0]  num_steps_r;
  logic [31:0] up_r, down_r;
  logic [30:0] prob_r, disc_r;

  logic [31:0] spot_r, strike_r;
  logic [LVL_W-1:0] lvl_r, lvl_nxt, t_r, t_nxt, tgt, n_eff;
  logic leaf_r, leaf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic out_sat_r;

  logic accept, at_tgt, src_load, out_load, american;
  logic [31:0] src_spot;
  logic [30:0] q_eff, disc_eff;
  cell_ctrl_t ctrl;

  logic [31:0] lane_w [NUM_CELLS+1];
  logic        lane_clip_w [NUM_CELLS+1];
  logic [31:0] val_w [NUM_CELLS+1];
  logic        flag_w [NUM_CELLS+1];

  assign american = mode_r[1];
  assign q_eff    = (prob_r > ONE_Q30) ? ONE_Q30 : prob_r;
  assign disc_eff = (disc_r > ONE_Q30) ? ONE_Q30 : disc_r;
  assign n_eff    = (32'(num_steps_r) > 32'(STEPS_MAX)) ? LVL_W'(STEPS_MAX)
                                                        : LVL_W'(num_steps_r);
  assign tgt      = leaf_r ? lvl_r : lvl_r - LVL_W'(1);
  assign at_tgt   = (t_r == tgt);
  assign accept   = in_tvalid && in_tready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      num_steps_r <= RST_NUM_STEPS;
      up_r        <= RST_UP;
      down_r      <= RST_DOWN;
      prob_r      <= RST_PROB;
      disc_r      <= RST_DISC;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE:      mode_r      <= cfg_wdata[1:0];
        CFG_NUM_STEPS: num_steps_r <= cfg_wdata[7:0];
        CFG_UP:        up_r        <= cfg_wdata;
        CFG_DOWN:      down_r      <= cfg_wdata;
        CFG_PROB:      prob_r      <= cfg_wdata[30:0];
        CFG_DISC:      disc_r      <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (at_tgt) begin
          if (leaf_r && lvl_r == '0) state_nxt = ST_DONE;
          else if (leaf_r && american) state_nxt = ST_RUN;
          else state_nxt = ST_COMB_A;
        end
      end
      ST_COMB_A: state_nxt = ST_COMB_B;
      ST_COMB_B: begin
        if (lvl_r == LVL_W'(1)) state_nxt = ST_DONE;
        else if (american) state_nxt = ST_RUN;
        else state_nxt = ST_COMB_A;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready     = 1'b0;
    src_load      = 1'b0;
    ctrl.capture  = 1'b0;
    ctrl.leaf     = leaf_r;
    ctrl.comb_a   = 1'b0;
    ctrl.comb_b   = 1'b0;
    ctrl.put      = mode_r[0];
    ctrl.american = american;
    case (state_r)
      ST_IDLE: begin
        in_tready = rst_n;
        src_load  = in_tvalid;
      end
      ST_RUN: begin
        ctrl.capture = at_tgt;
        src_load     = at_tgt && leaf_r && american && lvl_r != '0;
      end
      ST_COMB_A: ctrl.comb_a = 1'b1;
      ST_COMB_B: begin
        ctrl.comb_b = 1'b1;
        src_load    = american && lvl_r != LVL_W'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    lvl_nxt  = lvl_r;
    t_nxt    = t_r;
    leaf_nxt = leaf_r;
    if (accept) begin
      lvl_nxt  = n_eff;
      leaf_nxt = 1'b1;
    end
    if (state_r == ST_RUN && !at_tgt) t_nxt = t_r + LVL_W'(1);
    if (src_load) t_nxt = '0;
    if (ctrl.capture && leaf_r) leaf_nxt = 1'b0;
    if (ctrl.comb_b) lvl_nxt = lvl_r - LVL_W'(1);
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      t_r         <= '0;
      leaf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      t_r         <= t_nxt;
      leaf_r      <= leaf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      spot_r   <= in_tdata[31:0];
      strike_r <= in_tdata[63:32];
    end
    if (out_load) begin
      out_value_r <= val_w[0];
      out_sat_r   <= flag_w[0];
    end
  end

  assign src_spot = (state_r == ST_IDLE) ? in_tdata[31:0] : spot_r;

  bto_source u_source (
    .clk   (clk),
    .load  (src_load),
    .spot  (src_spot),
    .up    (up_r),
    .price (lane_w[0]),
    .clip  (lane_clip_w[0])
  );

  assign val_w[NUM_CELLS]  = '0;
  assign flag_w[NUM_CELLS] = 1'b0;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    bto_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .down          (down_r),
      .q             (q_eff),
      .disc          (disc_eff),
      .strike        (strike_r),
      .lane_in       (lane_w[c]),
      .lane_in_clip  (lane_clip_w[c]),
      .lane_out      (lane_w[c+1]),
      .lane_out_clip (lane_clip_w[c+1]),
      .val_right     (val_w[c+1]),
      .flag_right    (flag_w[c+1]),
      .val_out       (val_w[c]),
      .flag_out      (flag_w[c])
    );
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_sat_r;

  `BTO_ASSERT(a_accept_starts_pass, accept |=> (state_r == ST_RUN && t_r == '0 && leaf_r))
  `BTO_NEVER(a_count_past_target, state_r == ST_RUN && t_r > tgt)
  `BTO_NEVER(a_level_in_range, state_r != ST_IDLE && 32'(lvl_r) > 32'(STEPS_MAX))
  `BTO_ASSERT(a_comb_pairs, state_r == ST_COMB_A |=> state_r == ST_COMB_B)

endmodule
